// ===== hdl/rseq_pkg.sv =====
// Shared types, codes and helpers for the radio event sequencer.
// No dependencies; rseq_out_stage and the core import this package.
`timescale 1ns / 1ps

package rseq_pkg;

   // Input actions
   localparam logic [1:0] ACT_ORDER = 2'd0;
   localparam logic [1:0] ACT_END   = 2'd1;

   // Job types as stored
   localparam logic [1:0] JOB_RX    = 2'd0;
   localparam logic [1:0] JOB_RXP   = 2'd1;
   localparam logic [1:0] JOB_TX    = 2'd2;
   // unused type code on an order, folded to plain rx
   localparam logic [1:0] JOB_SPARE = 2'd3;

   // Result kinds
   localparam logic [2:0] KIND_STATUS = 3'd0;
   localparam logic [2:0] KIND_RX_REP = 3'd1;
   localparam logic [2:0] KIND_TX_REP = 3'd2;
   localparam logic [2:0] KIND_START  = 3'd3;
   localparam logic [2:0] KIND_IDLE   = 3'd4;
   localparam logic [2:0] KIND_EMPTY  = 3'd5;

   // Order status codes
   localparam logic [1:0] ORD_ACCEPTED = 2'd0;
   localparam logic [1:0] ORD_BAD_ADDR = 2'd1;
   localparam logic [1:0] ORD_FULL     = 2'd2;

   // Radio modes
   localparam logic [1:0] MODE_RX  = 2'd0;
   localparam logic [1:0] MODE_TX  = 2'd1;
   localparam logic [1:0] MODE_OFF = 2'd2;
   localparam logic [1:0] MODE_NEW = 2'd3;

   localparam logic [31:0] DEFAULT_AA   = 32'h8E89BED6;
   localparam logic [31:0] CRC_PURGED   = 32'hFFFFFFFF;
   localparam logic [6:0]  RSSI_ABSENT  = 7'd100;
   localparam logic [2:0]  RX_MASK_ONE  = 3'd1;
   localparam logic [2:0]  RX_MASK_BOTH = 3'd3;
   localparam logic [2:0]  MAX_TX_ADDR  = 3'd1;
   // at most this many purged jobs per service transaction
   localparam logic [2:0]  PURGE_LIMIT  = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  channel;
      logic [2:0]  address;
      logic [7:0]  power;
      logic [15:0] packet;
   } job_entry_type;

   localparam int JOB_BITS = $bits(job_entry_type);

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  order_status;
      logic [15:0] packet_handle;
      logic        crc_passed;
      logic [31:0] crc_word;
      logic [6:0]  rssi_out;
      logic [5:0]  start_channel;
      logic [6:0]  start_frequency;
      logic        start_is_tx;
      logic [7:0]  start_power;
      logic [2:0]  start_address;
      logic        last;
   } rsp_payload_type;

   // BLE channel index to offset from 2400 MHz; high channels map like 39
   function automatic logic [6:0] chan_freq(input logic [5:0] ch);
      logic [6:0] dbl;
      dbl = {ch, 1'b0};
      if (ch <= 6'd10) begin
         chan_freq = dbl + 7'd4;
      end else if (ch <= 6'd36) begin
         chan_freq = dbl + 7'd6;
      end else if (ch == 6'd37) begin
         chan_freq = 7'd2;
      end else if (ch == 6'd38) begin
         chan_freq = 7'd26;
      end else begin
         chan_freq = 7'd80;
      end
   endfunction

endpackage

// ===== hdl/rseq_req_if.sv =====
// Request channel of the sequencer: valid/ready handshake plus job and event fields.
// No dependencies.
`timescale 1ns / 1ps

interface rseq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [1:0]  job_type;
   logic [5:0]  job_channel;
   logic [2:0]  job_address;
   logic [7:0]  job_power;
   logic [15:0] job_packet;
   logic        end_crc_ok;
   logic [23:0] end_crc_value;
   logic        end_rssi_valid;
   logic [6:0]  end_rssi;

   modport source (
      output valid, action, job_type, job_channel, job_address, job_power, job_packet,
             end_crc_ok, end_crc_value, end_rssi_valid, end_rssi,
      input  ready
   );
   modport sink (
      input  valid, action, job_type, job_channel, job_address, job_power, job_packet,
             end_crc_ok, end_crc_value, end_rssi_valid, end_rssi,
      output ready
   );
endinterface

// ===== hdl/rseq_rsp_if.sv =====
// Response channel of the sequencer: valid/ready handshake plus result fields.
// No dependencies.
`timescale 1ns / 1ps

interface rseq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [1:0]  order_status;
   logic [15:0] packet_handle;
   logic        crc_passed;
   logic [31:0] crc_word;
   logic [6:0]  rssi_out;
   logic [5:0]  start_channel;
   logic [6:0]  start_frequency;
   logic        start_is_tx;
   logic [7:0]  start_power;
   logic [2:0]  start_address;
   logic        last;

   modport source (
      output valid, kind, order_status, packet_handle, crc_passed, crc_word, rssi_out,
             start_channel, start_frequency, start_is_tx, start_power, start_address, last,
      input  ready
   );
   modport sink (
      input  valid, kind, order_status, packet_handle, crc_passed, crc_word, rssi_out,
             start_channel, start_frequency, start_is_tx, start_power, start_address, last,
      output ready
   );
endinterface

// ===== hdl/rseq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rseq_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rseq_out_stage.sv =====
// One-entry output register for results, decoupling the sequencer from the sink.
// Depends on rseq_pkg and rseq_rsp_if.
`timescale 1ns / 1ps

module rseq_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rseq_pkg::rsp_payload_type push_data,
   output logic                     free,
   rseq_rsp_if.source               rsp_chan
);
   import rseq_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;

   // space when empty or the held transaction leaves this cycle
   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = push || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.kind            = data_ff.kind;
   assign rsp_chan.order_status    = data_ff.order_status;
   assign rsp_chan.packet_handle   = data_ff.packet_handle;
   assign rsp_chan.crc_passed      = data_ff.crc_passed;
   assign rsp_chan.crc_word        = data_ff.crc_word;
   assign rsp_chan.rssi_out        = data_ff.rssi_out;
   assign rsp_chan.start_channel   = data_ff.start_channel;
   assign rsp_chan.start_frequency = data_ff.start_frequency;
   assign rsp_chan.start_is_tx     = data_ff.start_is_tx;
   assign rsp_chan.start_power     = data_ff.start_power;
   assign rsp_chan.start_address   = data_ff.start_address;
   assign rsp_chan.last            = data_ff.last;

endmodule

// ===== hdl/radio_event_sequencer_core.sv =====
// Top level of the radio event sequencer: job queue, control sequencer, APB register.
// Depends on rseq_pkg, rseq_req_if, rseq_rsp_if, rseq_ram and rseq_out_stage.
// An order's status is pushed from S_ORDER into the output register; the next request is
// taken once the sequencer is back in S_IDLE. End and service events read the queue
// through its one registered read port (S_END_RD, S_PURGE_RD, S_START_RD); output stalls
// hold the sequencer. Results leave through a one-entry output register. Synchronous
// active-high reset empties the queue and sets the radio to never used; entries not cleared.
`timescale 1ns / 1ps

module radio_event_sequencer_core #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   rseq_req_if.sink    req_chan,
   rseq_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rseq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ORDER     = 4'd1;
   localparam logic [3:0] S_END       = 4'd2;
   localparam logic [3:0] S_END_RD    = 4'd3;
   localparam logic [3:0] S_END_REP   = 4'd4;
   localparam logic [3:0] S_PURGE     = 4'd5;
   localparam logic [3:0] S_PURGE_RD  = 4'd6;
   localparam logic [3:0] S_PURGE_CHK = 4'd7;
   localparam logic [3:0] S_MODE      = 4'd8;
   localparam logic [3:0] S_START_RD  = 4'd9;
   localparam logic [3:0] S_START     = 4'd10;

   logic [3:0]      state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [1:0]      mode_ff, mode_in;
   logic [2:0]      purged_ff, purged_in;
   logic [31:0]     alt_aa_ff;

   // captured request fields
   logic [1:0]      type_ff;
   logic [5:0]      chan_ff;
   logic [2:0]      addr_ff;
   logic [7:0]      power_ff;
   logic [15:0]     packet_ff;
   logic            crc_ok_ff;
   logic [23:0]     crc_ff;
   logic            rssi_valid_ff;
   logic [6:0]      rssi_ff;

   logic            req_take;
   logic            push;
   logic            out_free;
   rsp_payload_type res;
   logic            wr_en;
   job_entry_type   wr_job;
   logic [AW-1:0]   tail;
   logic [CW:0]     tail_sum;
   logic [AW-1:0]   head_next;
   logic            queue_full;
   logic [JOB_BITS-1:0] rd_bits;
   job_entry_type   rd_job;

   // APB register
   assign pready = 1'b1;
   assign prdata = alt_aa_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_aa_ff <= DEFAULT_AA;
      end else if (psel && penable && pwrite && (paddr == paddr)) begin
         alt_aa_ff <= pwdata;
      end
   end

   // queue pointers
   assign tail_sum   = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail       = (tail_sum >= (CW+1)'(QUEUE_DEPTH))
                       ? AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
   assign head_next  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign queue_full = (count_ff == CW'(QUEUE_DEPTH));

   // stored entry for an order; unused type code is kept as plain rx
   always_comb begin
      wr_job.kind    = (type_ff == JOB_SPARE) ? JOB_RX : type_ff;
      wr_job.channel = chan_ff;
      wr_job.address = addr_ff;
      wr_job.power   = power_ff;
      wr_job.packet  = packet_ff;
   end

   rseq_ram #(
      .WIDTH (JOB_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data (wr_job),
      .rd_addr (head_ff),
      .rd_data (rd_bits)
   );

   assign rd_job = rd_bits;

   rseq_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (res),
      .free      (out_free),
      .rsp_chan  (rsp_chan)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      mode_in   = mode_ff;
      purged_in = purged_ff;
      push      = 1'b0;
      wr_en     = 1'b0;
      res       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               purged_in = '0;
               if (req_chan.action == ACT_ORDER) begin
                  state_in = S_ORDER;
               end else if (req_chan.action == ACT_END) begin
                  state_in = S_END;
               end else begin
                  state_in = S_PURGE;
               end
            end
         end
         S_ORDER: begin
            res.kind = KIND_STATUS;
            res.last = 1'b1;
            if (type_ff == JOB_TX && addr_ff > MAX_TX_ADDR) begin
               res.order_status = ORD_BAD_ADDR;
            end else if (queue_full) begin
               res.order_status = ORD_FULL;
            end else begin
               res.order_status = ORD_ACCEPTED;
            end
            if (out_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
               if (res.order_status == ORD_ACCEPTED) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
         end
         S_END: begin
            if (count_ff == '0) begin
               res.kind = KIND_EMPTY;
               if (out_free) begin
                  push     = 1'b1;
                  mode_in  = MODE_OFF;
                  state_in = S_MODE;
               end
            end else begin
               state_in = S_END_RD;
            end
         end
         S_END_RD: begin
            state_in = S_END_REP;
         end
         S_END_REP: begin
            res.packet_handle = rd_job.packet;
            if (rd_job.kind == JOB_TX) begin
               res.kind = KIND_TX_REP;
            end else begin
               res.kind       = KIND_RX_REP;
               res.crc_passed = crc_ok_ff;
               res.crc_word   = {8'd0, crc_ff};
               res.rssi_out   = rssi_valid_ff ? rssi_ff : RSSI_ABSENT;
            end
            if (out_free) begin
               push     = 1'b1;
               head_in  = head_next;
               count_in = count_ff - CW'(1);
               mode_in  = MODE_OFF;
               state_in = S_MODE;
            end
         end
         S_PURGE: begin
            if (count_ff > CW'(1) && purged_ff != PURGE_LIMIT) begin
               state_in = S_PURGE_RD;
            end else begin
               state_in = S_MODE;
            end
         end
         S_PURGE_RD: begin
            state_in = S_PURGE_CHK;
         end
         S_PURGE_CHK: begin
            res.kind          = KIND_RX_REP;
            res.packet_handle = rd_job.packet;
            res.crc_word      = CRC_PURGED;
            res.rssi_out      = RSSI_ABSENT;
            if (rd_job.kind != JOB_RXP) begin
               state_in = S_MODE;
            end else if (out_free) begin
               push      = 1'b1;
               head_in   = head_next;
               count_in  = count_ff - CW'(1);
               mode_in   = MODE_OFF;
               purged_in = purged_ff + 3'd1;
               state_in  = S_PURGE;
            end
         end
         S_MODE: begin
            // a busy radio after nothing purged means no results at all
            if (mode_ff == MODE_OFF || mode_ff == MODE_NEW) begin
               if (count_ff == '0) begin
                  res.kind = KIND_IDLE;
                  res.last = 1'b1;
                  if (out_free) begin
                     push     = 1'b1;
                     state_in = S_IDLE;
                  end
               end else begin
                  state_in = S_START_RD;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_START_RD: begin
            state_in = S_START;
         end
         S_START: begin
            res.kind            = KIND_START;
            res.last            = 1'b1;
            res.packet_handle   = rd_job.packet;
            res.start_channel   = rd_job.channel;
            res.start_frequency = chan_freq(rd_job.channel);
            if (rd_job.kind == JOB_TX) begin
               res.start_is_tx   = 1'b1;
               res.start_power   = rd_job.power;
               res.start_address = rd_job.address;
            end else begin
               res.start_address = (alt_aa_ff != DEFAULT_AA) ? RX_MASK_BOTH : RX_MASK_ONE;
            end
            if (out_free) begin
               push     = 1'b1;
               mode_in  = (rd_job.kind == JOB_TX) ? MODE_TX : MODE_RX;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         mode_ff   <= MODE_NEW;
         purged_ff <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         mode_ff   <= mode_in;
         purged_ff <= purged_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         type_ff       <= req_chan.job_type;
         chan_ff       <= req_chan.job_channel;
         addr_ff       <= req_chan.job_address;
         power_ff      <= req_chan.job_power;
         packet_ff     <= req_chan.job_packet;
         crc_ok_ff     <= req_chan.end_crc_ok;
         crc_ff        <= req_chan.end_crc_value;
         rssi_valid_ff <= req_chan.end_rssi_valid;
         rssi_ff       <= req_chan.end_rssi;
      end
   end

endmodule
